[hw/rtl/smed_pkg.sv]
package smed_pkg;

   // Fixed widths of the transfer fields.
   localparam int SAMPLE_WIDTH = 16;
   localparam int MEDIAN_WIDTH = SAMPLE_WIDTH + 1;
   localparam int SIZE_WIDTH   = 6;

   // One input transfer: a value of the set and the end-of-set mark.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           final_item;
   } smed_req_type;

   // One result transfer.
   typedef struct packed {
      logic signed [MEDIAN_WIDTH-1:0] median_doubled;
      logic [SIZE_WIDTH-1:0]          set_size;
      logic                           overflowed;
   } smed_rsp_type;

   // Commands broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift_down;
   } smed_ctrl_type;

   // Sequencer states.
   typedef enum logic {
      SMED_IDLE,
      SMED_DRAIN
   } smed_state_type;

endpackage

[hw/rtl/smed_cell.sv]
module smed_cell
   import smed_pkg::*;
(
   input  logic                           clock,
   input  smed_ctrl_type                  ctrl,
   input  logic                           occupied,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   input  logic signed [SAMPLE_WIDTH-1:0] lower_value,
   input  logic                           lower_gt,
   input  logic signed [SAMPLE_WIDTH-1:0] upper_value,
   output logic signed [SAMPLE_WIDTH-1:0] value,
   output logic                           gt
);

   logic signed [SAMPLE_WIDTH-1:0] value_ff;
   logic signed [SAMPLE_WIDTH-1:0] value_in;

   // An empty cell counts as holding a value above any new sample.
   assign gt = !occupied || (value_ff > sample_in);

   // On insertion the larger values move up by one place; the lowest cell that
   // held a larger value or was empty takes the sample itself. While the
   // result is formed the chain moves down by one place each cycle.
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (gt) begin
            value_in = lower_gt ? lower_value : sample_in;
         end
      end else if (ctrl.shift_down) begin
         value_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[hw/rtl/set_median_engine_unit.sv]
// Median of a set by a sorted insertion chain of CAPACITY cells.
// A value that does not end a set is taken as soon as it is offered; the next may follow at once.
// After the transfer of the final value of a set, busy stays high while the chain drains
// down one cell a cycle to the middle values;
// the result strobe is high in the cycle after that. The receiver cannot stall the result.
// Reset (synchronous, active high) empties the chain and clears the overflow flag at once.
module set_median_engine_unit
   import smed_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  smed_req_type req_data,
   output logic         rsp_strobe,
   output smed_rsp_type rsp_data
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int SECOND = (CAPACITY > 1) ? 1 : 0;

   smed_state_type state_ff, state_in;
   logic [CW-1:0]  fill_count_ff, fill_count_in;
   logic [CW-1:0]  shift_count_ff, shift_count_in;
   logic           overflow_ff, overflow_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   smed_rsp_type   rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           full;
   logic           at_middle;
   logic [CW-1:0]  fill_minus_one;
   logic [CW-1:0]  mid_low;
   smed_ctrl_type  ctrl;

   logic signed [SAMPLE_WIDTH-1:0] cell_value [CAPACITY];
   logic                           cell_gt    [CAPACITY];
   logic signed [SAMPLE_WIDTH-1:0] second_value;

   assign accept         = start && !busy;
   assign full           = (fill_count_ff == CW'(CAPACITY));
   assign fill_minus_one = fill_count_ff - CW'(1);
   assign mid_low        = fill_minus_one >> 1;
   assign at_middle      = (shift_count_ff == mid_low);

   // Commands to the chain.
   assign ctrl.insert     = accept && !full;
   assign ctrl.shift_down = (state_ff == SMED_DRAIN) && !at_middle;

   // The chain of cells; cell 0 holds the smallest value.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] INDEX = CW'(i);
      localparam int LOWER = (i > 0) ? i - 1 : 0;
      localparam int UPPER = (i < CAPACITY - 1) ? i + 1 : i;

      smed_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (INDEX < fill_count_ff),
         .sample_in   (req_data.sample),
         .lower_value (cell_value[LOWER]),
         .lower_gt    ((i > 0) ? cell_gt[LOWER] : 1'b0),
         .upper_value (cell_value[UPPER]),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   // With the lower middle value in cell 0, an odd count doubles it and an
   // even count adds the upper middle value from cell 1.
   assign second_value = fill_count_ff[0] ? cell_value[0] : cell_value[SECOND];

   // Sequencer: next state and result.
   always_comb begin
      state_in       = state_ff;
      fill_count_in  = fill_count_ff;
      shift_count_in = shift_count_ff;
      overflow_in    = overflow_ff;
      rsp_strobe_in  = 1'b0;
      rsp_data_in    = rsp_data_ff;
      busy           = (state_ff != SMED_IDLE);
      case (state_ff)
         SMED_IDLE: begin
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  fill_count_in = fill_count_ff + CW'(1);
               end
               if (req_data.final_item) begin
                  state_in       = SMED_DRAIN;
                  shift_count_in = '0;
               end
            end
         end
         SMED_DRAIN: begin
            if (at_middle) begin
               rsp_strobe_in              = 1'b1;
               rsp_data_in.median_doubled =
                  {cell_value[0][SAMPLE_WIDTH-1], cell_value[0]} +
                  {second_value[SAMPLE_WIDTH-1], second_value};
               rsp_data_in.set_size       = SIZE_WIDTH'(fill_count_ff);
               rsp_data_in.overflowed     = overflow_ff;
               fill_count_in              = '0;
               overflow_in                = 1'b0;
               state_in                   = SMED_IDLE;
            end else begin
               shift_count_in = shift_count_ff + CW'(1);
            end
         end
         default: begin
            state_in = SMED_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SMED_IDLE;
         fill_count_ff  <= '0;
         shift_count_ff <= '0;
         overflow_ff    <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_count_ff  <= fill_count_in;
         shift_count_ff <= shift_count_in;
         overflow_ff    <= overflow_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef ASSERT_OFF
   // The chain never holds more values than it has cells.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   // A set that is being drained always holds at least one value.
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SMED_DRAIN) |-> (fill_count_ff != '0))
      else $error("drain with an empty chain");

   // Busy rises only after the transfer of a final value.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_data.final_item))
      else $error("busy without a final transfer");

   // A result is shown only once the sequencer has returned to idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(state_ff == SMED_DRAIN))
      else $error("result strobe outside the end of a drain");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import smed_pkg::*;

   localparam int CAPACITY    = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 325;

   // One row of the directed table: the sample is repeated reps times and
   // only the last copy carries the final mark.
   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      bit                             final_item;
      int                             reps;
      bit                             pinned;
      smed_rsp_type                   want;
   } set_row_type;

   localparam int ROW_COUNT = 21;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   smed_req_type req_data = '0;
   logic         rsp_strobe;
   smed_rsp_type rsp_data;

   // A typed expectation travels with the item it belongs to.
   logic         pin_valid = 1'b0;
   smed_rsp_type pin_want  = '0;

   // Shadow copy of the sorted chain.
   logic signed [SAMPLE_WIDTH-1:0] chain_vals [CAPACITY];
   int           chain_fill     = 0;
   bit           chain_overflow = 1'b0;

   smed_rsp_type median_q [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int overflow_sets  = 0;
   int stall_cycles   = 0;
   int idle_pct       = 0;

   set_row_type set_table [ROW_COUNT] = '{
      // Single values at both extremes and zero.
      '{16'sh7fff, 1'b1, 1, 1'b1, {17'h0fffe, 6'd1, 1'b0}},
      '{16'sh8000, 1'b1, 1, 1'b1, {17'h10000, 6'd1, 1'b0}},
      '{16'sh0000, 1'b1, 1, 1'b1, {17'h00000, 6'd1, 1'b0}},
      // Two equal extremes, then the two opposite extremes.
      '{16'sh7fff, 1'b0, 1, 1'b0, '0},
      '{16'sh7fff, 1'b1, 1, 1'b1, {17'h0fffe, 6'd2, 1'b0}},
      '{16'sh8000, 1'b0, 1, 1'b0, '0},
      '{16'sh8000, 1'b1, 1, 1'b1, {17'h10000, 6'd2, 1'b0}},
      '{16'sh8000, 1'b0, 1, 1'b0, '0},
      '{16'sh7fff, 1'b1, 1, 1'b1, {17'h1ffff, 6'd2, 1'b0}},
      // Odd count, unsorted arrival.
      '{16'sd5,    1'b0, 1, 1'b0, '0},
      '{-16'sd7,   1'b0, 1, 1'b0, '0},
      '{16'sd3,    1'b1, 1, 1'b0, '0},
      // Even count whose middle pair sums to an odd value.
      '{16'sd10,   1'b0, 1, 1'b0, '0},
      '{-16'sd2,   1'b0, 1, 1'b0, '0},
      '{16'sd7,    1'b0, 1, 1'b0, '0},
      '{16'sd100,  1'b1, 1, 1'b0, '0},
      // Equal values throughout.
      '{16'sd4,    1'b0, 2, 1'b0, '0},
      '{16'sd4,    1'b1, 1, 1'b0, '0},
      // Chain filled and overrun; the final value itself is dropped.
      '{16'sd100,  1'b0, 33, 1'b0, '0},
      '{-16'sd5,   1'b1, 1, 1'b1, {17'h000c8, 6'd32, 1'b1}},
      // A value right after an overflowed set starts a fresh chain.
      '{-16'sd9,   1'b1, 1, 1'b1, {17'h1ffee, 6'd1, 1'b0}}
   };

   set_median_engine_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Insert one sample into the shadow chain and, on the final mark, form the
   // doubled median of the kept values and empty the chain.
   function automatic void insert_sample(input smed_req_type item, output bit made,
                                         output smed_rsp_type rsp);
      int pos;
      int doubled;
      int n;
      made = 1'b0;
      rsp  = '0;
      if (chain_fill >= CAPACITY) begin
         chain_overflow = 1'b1;
      end else begin
         pos = chain_fill;
         while (pos > 0 && chain_vals[pos-1] > item.sample) begin
            chain_vals[pos] = chain_vals[pos-1];
            pos--;
         end
         chain_vals[pos] = item.sample;
         chain_fill++;
      end
      if (item.final_item) begin
         n = chain_fill;
         if (n % 2 == 1)
            doubled = 2 * int'(chain_vals[n/2]);
         else
            doubled = int'(chain_vals[n/2-1]) + int'(chain_vals[n/2]);
         rsp.median_doubled = doubled[MEDIAN_WIDTH-1:0];
         rsp.set_size       = n[SIZE_WIDTH-1:0];
         rsp.overflowed     = chain_overflow;
         made           = 1'b1;
         chain_fill     = 0;
         chain_overflow = 1'b0;
      end
   endfunction

   // Check result transfers against the oldest expectation, then predict from
   // any input transfer taken at the same edge.
   always @(posedge clock) begin
      smed_rsp_type want;
      bit made;
      if (!reset) begin
         if (rsp_strobe) begin
            results_seen++;
            if (median_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with nothing expected: median2=%0d size=%0d ovf=%0b",
                        $time, rsp_data.median_doubled, rsp_data.set_size,
                        rsp_data.overflowed);
            end else begin
               want = median_q.pop_front();
               if (rsp_data.median_doubled !== want.median_doubled ||
                   rsp_data.set_size !== want.set_size ||
                   rsp_data.overflowed !== want.overflowed) begin
                  mismatch_count++;
                  $display({"%0t: mismatch: expected median2=%0d size=%0d ovf=%0b, ",
                            "got median2=%0d size=%0d ovf=%0b"},
                           $time, want.median_doubled, want.set_size, want.overflowed,
                           rsp_data.median_doubled, rsp_data.set_size, rsp_data.overflowed);
               end
            end
         end
         if (start && !busy) begin
            insert_sample(req_data, made, want);
            if (made) begin
               if (want.overflowed)
                  overflow_sets++;
               median_q.push_back(pin_valid ? pin_want : want);
            end
         end
      end
   end

   // Watchdog on cycles in which no transfer happens in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Present one item and hold it until the block takes it; a random gap may
   // come first, depending on the current idle rate.
   task automatic offer_item(input logic signed [SAMPLE_WIDTH-1:0] sample,
                             input bit final_item, input bit pin, input smed_rsp_type want);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_data.sample     <= sample;
      req_data.final_item <= final_item;
      pin_valid           <= pin;
      pin_want            <= want;
      items_sent++;
      do @(posedge clock); while (busy);
   endtask

   // Hold the sender off until every expected result has arrived.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (median_q.size() != 0);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input int mode);
      case (mode)
         0: pick_sample = $signed(SAMPLE_WIDTH'($urandom));
         1: pick_sample = $signed(SAMPLE_WIDTH'($urandom_range(16))) - 16'sd8;
         2: pick_sample = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: pick_sample = $urandom_range(1)
                     ? 16'sh7fff - $signed(SAMPLE_WIDTH'($urandom_range(3)))
                     : 16'sh8000 + $signed(SAMPLE_WIDTH'($urandom_range(3)));
      endcase
   endfunction

   // Random sets: mostly short, some of medium length, some filling the chain exactly, a few overrunning it.
   task automatic run_random_sets(input int budget);
      int first;
      int len;
      int mode;
      int pick;
      first = items_sent;
      while (items_sent - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 60)
            len = $urandom_range(1, 8);
         else if (pick < 85)
            len = $urandom_range(9, 31);
         else if (pick < 93)
            len = CAPACITY;
         else
            len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
         mode = $urandom_range(3);
         for (int i = 0; i < len; i++)
            offer_item(pick_sample(mode), i == len - 1, 1'b0, '0);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no idling.
      idle_pct = 0;
      foreach (set_table[r]) begin
         for (int k = 0; k < set_table[r].reps; k++) begin
            offer_item(set_table[r].sample,
                       set_table[r].final_item && k == set_table[r].reps - 1,
                       set_table[r].pinned && k == set_table[r].reps - 1,
                       set_table[r].want);
         end
      end
      drain_results();

      // Random phases with the sender idling at different rates.
      idle_pct = 0;
      run_random_sets(ITEMS_PER_PHASE);
      drain_results();
      idle_pct = 53;
      run_random_sets(ITEMS_PER_PHASE);
      drain_results();
      idle_pct = 0;
      run_random_sets(ITEMS_PER_PHASE);
      idle_pct = 7;
      run_random_sets(ITEMS_PER_PHASE);

      // Wait for the last results, then allow for any trailing activity.
      drain_results();
      repeat (40) @(posedge clock);

      if (median_q.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d expected results never arrived", $time, median_q.size());
      end
      $display("Sent %0d samples and checked %0d median results, %0d from overrun sets.",
               items_sent, results_seen, overflow_sets);
      $display("Sender idle rates of 0, 53 and 7 percent were used; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
